// ===== src/tcw_pkg.sv =====
// Shared types, constants and the microcode table of the text console writer.
package tcw_pkg;

    // Field widths
    localparam int POS_W  = 11;
    localparam int CODE_W = 9;
    localparam int BYTE_W = 8;
    localparam int CELL_W = 16;
    localparam int STEP_W = 4;

    // Default screen geometry
    localparam int DEF_COLUMNS   = 80;
    localparam int DEF_ROWS_USED = 24;

    // Character and attribute codes
    localparam logic [CELL_W-1:0] ATTR      = 16'h0700;
    localparam logic [CODE_W-1:0] BS_CODE   = 9'h100;
    localparam logic [BYTE_W-1:0] NL_BYTE   = 8'h0A;
    localparam logic [BYTE_W-1:0] SP_BYTE   = 8'h20;
    localparam logic [BYTE_W-1:0] BS_BYTE   = 8'h08;

    // Microcode step addresses
    localparam logic [STEP_W-1:0] ST_CLR  = 4'd0;
    localparam logic [STEP_W-1:0] ST_IDLE = 4'd1;
    localparam logic [STEP_W-1:0] ST_CHR  = 4'd2;
    localparam logic [STEP_W-1:0] ST_NL   = 4'd3;
    localparam logic [STEP_W-1:0] ST_CHK  = 4'd4;
    localparam logic [STEP_W-1:0] ST_SCR  = 4'd5;
    localparam logic [STEP_W-1:0] ST_CPY  = 4'd6;
    localparam logic [STEP_W-1:0] ST_DRN  = 4'd7;
    localparam logic [STEP_W-1:0] ST_ZER  = 4'd8;
    localparam logic [STEP_W-1:0] ST_SPC  = 4'd9;
    localparam logic [STEP_W-1:0] ST_BS   = 4'd10;
    localparam logic [STEP_W-1:0] ST_BS1  = 4'd11;
    localparam logic [STEP_W-1:0] ST_BS2  = 4'd12;
    localparam logic [STEP_W-1:0] ST_BS3  = 4'd13;
    localparam logic [STEP_W-1:0] ST_RD   = 4'd14;
    localparam logic [STEP_W-1:0] ST_RD1  = 4'd15;

    // Screen store operation
    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_CHAR,   // write code | attribute at cursor
        MEM_SPACE,  // write attributed space at cursor
        MEM_ZERO,   // write zero at sweep counter
        MEM_COPY,   // read counter + one row, write back one row up next cycle
        MEM_READ    // read the requested cell
    } t_mem_op;

    // Cursor operation
    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_INC,
        CUR_NL,
        CUR_BS,
        CUR_LAST    // start of the bottom row after a scroll
    } t_cur_op;

    // Sweep counter operation
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_INC
    } t_cnt_op;

    // Serial echo byte select
    typedef enum logic [1:0] {
        SER_ZERO,
        SER_CODE,
        SER_BS,
        SER_SP
    } t_ser_sel;

    // Sequencer branch kind
    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_DISPATCH,       // wait for an item, then branch on its kind
        JMP_IF_NO_SCROLL,
        JMP_IF_CNT_NE_COPY,
        JMP_IF_CNT_NE_ALL
    } t_jmp;

    // One control word
    typedef struct packed {
        t_mem_op           mem;
        t_cur_op           cur;
        t_cnt_op           cnt;
        t_ser_sel          ser;
        logic              emit;
        logic              cell_sel;
        logic              last;
        logic              in_rdy;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
    } t_uword;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic in_read;
        logic in_bs;
        logic in_nl;
        logic scroll;
        logic cnt_copy_end;
        logic cnt_all_end;
    } t_dp_stat;

    // Microcode table
    function automatic t_uword uc_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{mem: MEM_NONE, cur: CUR_HOLD, cnt: CNT_HOLD, ser: SER_ZERO,
              emit: 1'b0, cell_sel: 1'b0, last: 1'b0, in_rdy: 1'b0,
              jmp: JMP_NEXT, target: ST_IDLE};
        case (step)
            ST_CLR: begin
                w.mem = MEM_ZERO; w.cnt = CNT_INC;
                w.jmp = JMP_IF_CNT_NE_ALL; w.target = ST_CLR;
            end
            ST_IDLE: begin
                w.in_rdy = 1'b1; w.jmp = JMP_DISPATCH; w.target = ST_IDLE;
            end
            ST_CHR: begin
                w.mem = MEM_CHAR; w.cur = CUR_INC;
                w.jmp = JMP_ALWAYS; w.target = ST_CHK;
            end
            ST_NL: begin
                w.cur = CUR_NL;
            end
            ST_CHK: begin
                w.jmp = JMP_IF_NO_SCROLL; w.target = ST_SPC;
            end
            ST_SCR: begin
                w.cnt = CNT_CLR;
            end
            ST_CPY: begin
                w.mem = MEM_COPY; w.cnt = CNT_INC;
                w.jmp = JMP_IF_CNT_NE_COPY; w.target = ST_CPY;
            end
            ST_DRN: begin
                // last copy write lands here
                w.cur = CUR_LAST;
            end
            ST_ZER: begin
                w.mem = MEM_ZERO; w.cnt = CNT_INC;
                w.jmp = JMP_IF_CNT_NE_ALL; w.target = ST_ZER;
            end
            ST_SPC: begin
                w.mem = MEM_SPACE; w.emit = 1'b1; w.ser = SER_CODE; w.last = 1'b1;
                w.jmp = JMP_ALWAYS; w.target = ST_IDLE;
            end
            ST_BS: begin
                w.cur = CUR_BS;
            end
            ST_BS1: begin
                w.mem = MEM_SPACE; w.emit = 1'b1; w.ser = SER_BS;
            end
            ST_BS2: begin
                w.emit = 1'b1; w.ser = SER_SP;
            end
            ST_BS3: begin
                w.emit = 1'b1; w.ser = SER_BS; w.last = 1'b1;
                w.jmp = JMP_ALWAYS; w.target = ST_IDLE;
            end
            ST_RD: begin
                w.mem = MEM_READ;
            end
            ST_RD1: begin
                w.emit = 1'b1; w.cell_sel = 1'b1; w.last = 1'b1;
                w.jmp = JMP_ALWAYS; w.target = ST_IDLE;
            end
            default: begin
                w.jmp = JMP_ALWAYS; w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== src/text_console_writer.sv =====
// Top level of the text console writer: sequencer, datapath and result register.
//
// Input channel (i_in_valid / o_in_ready) carries one item: i_mode 0 puts
// i_char_code (256 = backspace), i_mode 1 reads screen cell i_cell_index.
// Output channel (o_out_valid / i_out_ready) returns results: the echoed
// serial byte, the cursor after the item, the read cell, and o_last on the
// final result of the item. A backspace gives three results, all else one.
// The next item is taken only after the final result of the current item
// has been loaded into the output register.
// A put that runs off the bottom row scrolls the screen store, one cell per
// cycle over its single write port.
// After reset the store is swept to zero, all COLUMNS*ROWS_USED cells (1920 at
// the default size), and no item is taken until the sweep is done.
// A result waits in the output register while the receiver stalls; the
// sequencer holds at its next result step until that register frees up.
// The cursor_pos and cell_index ports are 11 bits, so the screen holds at
// most 2048 cells.
module text_console_writer #(
    parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS_USED = tcw_pkg::DEF_ROWS_USED
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_mode,
    input  logic [tcw_pkg::CODE_W-1:0]  i_char_code,
    input  logic [tcw_pkg::POS_W-1:0]   i_cell_index,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [tcw_pkg::BYTE_W-1:0]  o_serial_byte,
    output logic [tcw_pkg::POS_W-1:0]   o_cursor_pos,
    output logic [tcw_pkg::CELL_W-1:0]  o_cell_data,
    output logic                        o_last
);
    import tcw_pkg::*;

    localparam logic [POS_W-1:0] CELLS_P = POS_W'(COLUMNS * ROWS_USED);

    t_uword            uw;
    t_dp_stat          stat;
    logic              go;
    logic              in_ready;
    logic              accept;
    logic              out_busy;
    logic              load;
    logic [POS_W-1:0]  cursor;
    logic [BYTE_W-1:0] code;
    logic [CELL_W-1:0] rd_cell;
    logic [BYTE_W-1:0] ser;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_serial;
    logic [POS_W-1:0]  r_cursor;
    logic [CELL_W-1:0] r_cell;
    logic              r_last;

    assign accept   = i_in_valid && in_ready;
    assign out_busy = r_out_valid && !i_out_ready;
    assign load     = go && uw.emit;

    tcw_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_busy (out_busy),
        .i_stat     (stat),
        .o_uw       (uw),
        .o_go       (go),
        .o_in_ready (in_ready)
    );

    tcw_dp #(
        .COLUMNS   (COLUMNS),
        .ROWS_USED (ROWS_USED)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_uw         (uw),
        .i_go         (go),
        .i_accept     (accept),
        .i_mode       (i_mode),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .o_stat       (stat),
        .o_cursor     (cursor),
        .o_code       (code),
        .o_cell       (rd_cell)
    );

    // Echo byte select
    always_comb begin
        case (uw.ser)
            SER_ZERO: ser = '0;
            SER_CODE: ser = code;
            SER_BS:   ser = BS_BYTE;
            SER_SP:   ser = SP_BYTE;
            default:  ser = '0;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_serial <= ser;
            r_cursor <= cursor;
            r_cell   <= uw.cell_sel ? rd_cell : '0;
            r_last   <= uw.last;
        end
    end

    assign o_in_ready    = in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_serial_byte = r_serial;
    assign o_cursor_pos  = r_cursor;
    assign o_cell_data   = r_cell;
    assign o_last        = r_last;

    // Reported cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cursor_pos < CELLS_P))
        else $error("cursor beyond screen");

    // An accepted item takes the sequencer out of its wait step
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("input taken twice in a row");

    // No new item while a non-final result waits
    a_no_intake_midway: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> !o_in_ready)
        else $error("input ready before final result");

    // A result is never overwritten while stalled
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !load)
        else $error("result register overwritten");

endmodule

// ===== src/tcw_seq.sv =====
// Microcode sequencer: step counter, control table lookup and branch logic.
module tcw_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_busy,
    input  tcw_pkg::t_dp_stat i_stat,
    output tcw_pkg::t_uword   o_uw,
    output logic              o_go,
    output logic              o_in_ready
);
    import tcw_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic [STEP_W-1:0] step_inc;
    t_uword            uw;
    logic              stall;
    logic              accept;

    assign uw       = uc_rom(r_step);
    assign stall    = uw.emit && i_out_busy;
    assign accept   = i_in_valid && uw.in_rdy;
    assign step_inc = r_step + 1'b1;

    assign o_uw       = uw;
    assign o_go       = !stall;
    assign o_in_ready = uw.in_rdy;

    // Branch selection
    always_comb begin
        n_step = step_inc;
        case (uw.jmp)
            JMP_NEXT:   n_step = step_inc;
            JMP_ALWAYS: n_step = uw.target;
            JMP_DISPATCH: begin
                if (!accept)             n_step = uw.target;
                else if (i_stat.in_read) n_step = ST_RD;
                else if (i_stat.in_bs)   n_step = ST_BS;
                else if (i_stat.in_nl)   n_step = ST_NL;
                else                     n_step = ST_CHR;
            end
            JMP_IF_NO_SCROLL:   n_step = i_stat.scroll ? step_inc : uw.target;
            JMP_IF_CNT_NE_COPY: n_step = i_stat.cnt_copy_end ? step_inc : uw.target;
            JMP_IF_CNT_NE_ALL:  n_step = i_stat.cnt_all_end ? step_inc : uw.target;
            default:            n_step = ST_IDLE;
        endcase
        if (stall) n_step = r_step;
    end

    // Step counter; reset starts the screen clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_CLR;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== src/tcw_dp.sv =====
// Datapath: cursor, sweep counter, item latch and the screen cell store.
module tcw_dp #(
    parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS_USED = tcw_pkg::DEF_ROWS_USED
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tcw_pkg::t_uword              i_uw,
    input  logic                         i_go,
    input  logic                         i_accept,
    input  logic                         i_mode,
    input  logic [tcw_pkg::CODE_W-1:0]   i_char_code,
    input  logic [tcw_pkg::POS_W-1:0]    i_cell_index,
    output tcw_pkg::t_dp_stat            o_stat,
    output logic [tcw_pkg::POS_W-1:0]    o_cursor,
    output logic [tcw_pkg::BYTE_W-1:0]   o_code,
    output logic [tcw_pkg::CELL_W-1:0]   o_cell
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS_USED;
    localparam int AW    = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS_USED + 1);

    localparam logic [POS_W-1:0] CELLS_P   = POS_W'(CELLS);
    localparam logic [POS_W-1:0] COLS_P    = POS_W'(COLUMNS);
    localparam logic [POS_W-1:0] COPY_LAST = POS_W'(CELLS - COLUMNS - 1);
    localparam logic [POS_W-1:0] ALL_LAST  = POS_W'(CELLS - 1);
    localparam logic [POS_W-1:0] LAST_ROW  = POS_W'(CELLS - COLUMNS);
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_END   = ROW_W'(ROWS_USED);
    localparam logic [ROW_W-1:0] ROW_BOT   = ROW_W'(ROWS_USED - 1);

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rd_data;

    logic [POS_W-1:0]  r_cursor, n_cursor;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [POS_W-1:0]  r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_code;
    logic [POS_W-1:0]  r_idx;
    logic              r_idx_ok;
    logic              r_cp_pend;
    logic [POS_W-1:0]  r_cp_addr;

    logic              wr_en;
    logic [POS_W-1:0]  wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [POS_W-1:0]  rd_addr;
    logic              cp_issue;

    // Status for branching
    assign o_stat.in_read      = i_mode;
    assign o_stat.in_bs        = (i_char_code == BS_CODE);
    assign o_stat.in_nl        = (i_char_code[BYTE_W-1:0] == NL_BYTE);
    assign o_stat.scroll       = (r_row == ROW_END);
    assign o_stat.cnt_copy_end = (r_cnt == COPY_LAST);
    assign o_stat.cnt_all_end  = (r_cnt == ALL_LAST);

    assign o_cursor = r_cursor;
    assign o_code   = r_code;
    assign o_cell   = r_idx_ok ? r_rd_data : '0;

    // Cursor update, column and row kept alongside the linear position
    always_comb begin
        n_cursor = r_cursor;
        n_col    = r_col;
        n_row    = r_row;
        if (i_go) begin
            case (i_uw.cur)
                CUR_INC: begin
                    n_cursor = r_cursor + 1'b1;
                    if (r_col == COL_LAST) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
                CUR_NL: begin
                    n_cursor = r_cursor + COLS_P - POS_W'(r_col);
                    n_col    = '0;
                    n_row    = r_row + 1'b1;
                end
                CUR_BS: begin
                    if (r_cursor != '0) begin
                        n_cursor = r_cursor - 1'b1;
                        if (r_col == '0) begin
                            n_col = COL_LAST;
                            n_row = r_row - 1'b1;
                        end else begin
                            n_col = r_col - 1'b1;
                        end
                    end
                end
                CUR_LAST: begin
                    n_cursor = LAST_ROW;
                    n_row    = ROW_BOT;
                end
                default: ;
            endcase
        end
    end

    // Sweep counter
    always_comb begin
        n_cnt = r_cnt;
        if (i_go) begin
            case (i_uw.cnt)
                CNT_CLR: n_cnt = '0;
                CNT_INC: n_cnt = r_cnt + 1'b1;
                default: ;
            endcase
        end
    end

    // Store port control; a pending copy write uses last cycle's read data
    always_comb begin
        wr_en    = r_cp_pend;
        wr_addr  = r_cp_addr;
        wr_data  = r_rd_data;
        rd_en    = 1'b0;
        rd_addr  = r_cnt + COLS_P;
        cp_issue = 1'b0;
        if (i_go) begin
            case (i_uw.mem)
                MEM_CHAR: begin
                    wr_en   = 1'b1;
                    wr_addr = r_cursor;
                    wr_data = ATTR | {{(CELL_W-BYTE_W){1'b0}}, r_code};
                end
                MEM_SPACE: begin
                    wr_en   = 1'b1;
                    wr_addr = r_cursor;
                    wr_data = ATTR | {{(CELL_W-BYTE_W){1'b0}}, SP_BYTE};
                end
                MEM_ZERO: begin
                    wr_en   = 1'b1;
                    wr_addr = r_cnt;
                    wr_data = '0;
                end
                MEM_COPY: begin
                    rd_en    = 1'b1;
                    rd_addr  = r_cnt + COLS_P;
                    cp_issue = 1'b1;
                end
                MEM_READ: begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx_ok ? r_idx : '0;
                end
                default: ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor  <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_cnt     <= '0;
            r_cp_pend <= 1'b0;
        end else begin
            r_cursor  <= n_cursor;
            r_col     <= n_col;
            r_row     <= n_row;
            r_cnt     <= n_cnt;
            r_cp_pend <= cp_issue;
        end
    end

    // Item latch and copy address
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_code   <= i_char_code[BYTE_W-1:0];
            r_idx    <= i_cell_index;
            r_idx_ok <= (i_cell_index < CELLS_P);
        end
        r_cp_addr <= r_cnt;
    end

    // Screen store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr[AW-1:0]];
        end
    end

endmodule
